@@ rtl/ptc_pkg.sv @@
package ptc_pkg;

    localparam int unsigned RAW_W  = 20;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned CFG_W  = 64;

    typedef enum logic [1:0] {
        CFG_TEMP     = 2'd0,
        CFG_PRESS_LO = 2'd1,
        CFG_PRESS_HI = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [RAW_W-1:0] raw_temperature;
        logic [RAW_W-1:0] raw_pressure;
    } t_item;

    typedef struct packed {
        logic [CFG_W-1:0] temp_coeffs;
        logic [CFG_W-1:0] press_lo;
        logic [CFG_W-1:0] press_hi;
    } t_coeffs;

    function automatic logic [WORD_W-1:0] asr(input logic [WORD_W-1:0] x, input int n);
        asr = WORD_W'($signed(x) >>> n);
    endfunction

    function automatic logic [WORD_W-1:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction

endpackage

@@ rtl/ptc_front.sv @@
module ptc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ptc_pkg::t_item i_item,
    output logic          o_valid,
    input  logic          i_take,
    output ptc_pkg::t_item o_item
);
    import ptc_pkg::*;

    // two-entry queue between the input channel and the arithmetic pipeline
    t_item       r_mem [2];
    logic        r_wptr, r_rptr;
    logic [1:0]  r_cnt;
    logic        push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (push) r_wptr <= ~r_wptr;
            if (pop)  r_rptr <= ~r_rptr;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wptr] <= i_item;
    end

endmodule

@@ rtl/ptc_div.sv @@
module ptc_div #(
    parameter int TW = 35
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [31:0]   i_dividend,
    input  logic [31:0]   i_divisor,
    input  logic [TW-1:0] i_tag,
    output logic          o_vld,
    output logic [31:0]   o_quot,
    output logic [TW-1:0] o_tag
);
    import ptc_pkg::*;

    localparam int N = WORD_W;

    // one quotient bit per stage, restoring
    logic [31:0]   r_rem [N];
    logic [31:0]   r_dvd [N];
    logic [31:0]   r_q   [N];
    logic [31:0]   r_dvs [N];
    logic [TW-1:0] r_tag [N];
    logic [N-1:0]  r_v;

    logic [31:0]   s_rem [N+1];
    logic [31:0]   s_dvd [N+1];
    logic [31:0]   s_q   [N+1];
    logic [31:0]   s_dvs [N+1];
    logic [TW-1:0] s_tag [N+1];

    assign s_rem[0] = '0;
    assign s_dvd[0] = i_dividend;
    assign s_q[0]   = '0;
    assign s_dvs[0] = i_divisor;
    assign s_tag[0] = i_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[N-2:0], i_vld};
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [32:0] trial;
        logic [32:0] diff;
        logic        ge;

        assign trial = {s_rem[k], s_dvd[k][31]};
        assign diff  = trial - {1'b0, s_dvs[k]};
        assign ge    = (trial >= {1'b0, s_dvs[k]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? diff[31:0] : trial[31:0];
                r_q[k]   <= {s_q[k][30:0], ge};
                r_dvd[k] <= {s_dvd[k][30:0], 1'b0};
                r_dvs[k] <= s_dvs[k];
                r_tag[k] <= s_tag[k];
            end
        end

        assign s_rem[k+1] = r_rem[k];
        assign s_dvd[k+1] = r_dvd[k];
        assign s_q[k+1]   = r_q[k];
        assign s_dvs[k+1] = r_dvs[k];
        assign s_tag[k+1] = r_tag[k];
    end

    assign o_vld  = r_v[N-1];
    assign o_quot = s_q[N];
    assign o_tag  = s_tag[N];

endmodule

@@ rtl/ptc_back.sv @@
module ptc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ptc_pkg::t_coeffs i_coeffs,
    input  logic             i_valid,
    input  ptc_pkg::t_item   i_item,
    output logic             o_take,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [31:0]      o_temperature,
    output logic [31:0]      o_pressure,
    output logic             o_pressure_valid
);
    import ptc_pkg::*;

    localparam int TW = WORD_W + 2;

    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic        adv;

    assign t1 = {16'b0, i_coeffs.temp_coeffs[15:0]};
    assign t2 = sx16(i_coeffs.temp_coeffs[31:16]);
    assign t3 = sx16(i_coeffs.temp_coeffs[47:32]);
    assign p1 = {16'b0, i_coeffs.temp_coeffs[63:48]};
    assign p2 = sx16(i_coeffs.press_lo[15:0]);
    assign p3 = sx16(i_coeffs.press_lo[31:16]);
    assign p4 = sx16(i_coeffs.press_lo[47:32]);
    assign p5 = sx16(i_coeffs.press_lo[63:48]);
    assign p6 = sx16(i_coeffs.press_hi[15:0]);
    assign p7 = sx16(i_coeffs.press_hi[31:16]);
    assign p8 = sx16(i_coeffs.press_hi[47:32]);
    assign p9 = sx16(i_coeffs.press_hi[63:48]);

    // whole pipeline holds while the result register is full and not taken
    logic r_out_vld;
    assign adv    = !r_out_vld || i_out_ready;
    assign o_take = adv;

    logic [31:0] adc_t, adc_p;
    assign adc_t = {12'b0, i_item.raw_temperature};
    assign adc_p = {12'b0, i_item.raw_pressure};

    logic [9:1]  r_v;
    logic        r_v10, r_v11;
    logic [31:0] r1_m1, r1_dd, r1_adcp;
    logic [31:0] r2_a, r2_m2, r2_adcp;
    logic [31:0] r3_temp, r3_pa, r3_adcp;
    logic [31:0] r4_sq, r4_ap5, r4_p2a, r4_temp, r4_adcp;
    logic [31:0] r5_b1, r5_c1, r5_ap5, r5_p2a, r5_temp, r5_adcp;
    logic [31:0] r6_b, r6_a, r6_temp, r6_adcp;
    logic [31:0] r7_dv, r7_b, r7_temp, r7_adcp;
    logic [31:0] r8_num, r8_dv, r8_temp;
    logic [31:0] r9_dvd, r9_dvs, r9_temp;
    logic        r9_dbl, r9_ok;
    logic [31:0] r10_p, r10_m, r10_pa8, r10_temp;
    logic        r10_ok;
    logic [31:0] r11_p, r11_a, r11_b, r11_temp;
    logic        r11_ok;
    logic [31:0] r_temp, r_pres;
    logic        r_pok;

    logic [31:0] d, fine, q4, qp;
    logic [31:0] dq;
    logic [TW-1:0] dtag;
    logic          dvld;

    assign d    = (adc_t >> 4) - t1;
    assign fine = r2_a + asr(r2_m2, 14);
    assign q4   = asr(r3_pa, 2);
    assign qp   = dtag[0] ? {dq[30:0], 1'b0} : dq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v       <= '0;
            r_v10     <= 1'b0;
            r_v11     <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_v       <= {r_v[8:1], i_valid};
            r_v10     <= dvld;
            r_v11     <= r_v10;
            r_out_vld <= r_v11;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_m1   <= ((adc_t >> 3) - (t1 << 1)) * t2;
            r1_dd   <= d * d;
            r1_adcp <= adc_p;

            r2_a    <= asr(r1_m1, 11);
            r2_m2   <= asr(r1_dd, 12) * t3;
            r2_adcp <= r1_adcp;

            r3_temp <= asr((fine << 2) + fine + 32'd128, 8);
            r3_pa   <= asr(fine, 1) - 32'd64000;
            r3_adcp <= r2_adcp;

            r4_sq   <= q4 * q4;
            r4_ap5  <= r3_pa * p5;
            r4_p2a  <= p2 * r3_pa;
            r4_temp <= r3_temp;
            r4_adcp <= r3_adcp;

            r5_b1   <= asr(r4_sq, 11) * p6;
            r5_c1   <= p3 * asr(r4_sq, 13);
            r5_ap5  <= r4_ap5;
            r5_p2a  <= r4_p2a;
            r5_temp <= r4_temp;
            r5_adcp <= r4_adcp;

            r6_b    <= asr(r5_b1 + (r5_ap5 << 1), 2) + (p4 << 16);
            r6_a    <= asr(asr(r5_c1, 3) + asr(r5_p2a, 1), 18);
            r6_temp <= r5_temp;
            r6_adcp <= r5_adcp;

            r7_dv   <= asr((32'd32768 + r6_a) * p1, 15);
            r7_b    <= r6_b;
            r7_temp <= r6_temp;
            r7_adcp <= r6_adcp;

            r8_num  <= ((32'd1048576 - r7_adcp) - asr(r7_b, 12)) * 32'd3125;
            r8_dv   <= r7_dv;
            r8_temp <= r7_temp;

            // large dividends are divided first and doubled afterwards
            r9_dbl  <= r8_num[31];
            r9_dvd  <= r8_num[31] ? r8_num : {r8_num[30:0], 1'b0};
            r9_dvs  <= r8_dv;
            r9_ok   <= (r8_dv != '0);
            r9_temp <= r8_temp;

            r10_p    <= qp;
            r10_m    <= (qp >> 3) * (qp >> 3);
            r10_pa8  <= (qp >> 2) * p8;
            r10_ok   <= dtag[1];
            r10_temp <= dtag[TW-1:2];

            r11_p    <= r10_p;
            r11_a    <= asr(p9 * (r10_m >> 13), 12);
            r11_b    <= asr(r10_pa8, 13);
            r11_ok   <= r10_ok;
            r11_temp <= r10_temp;

            r_temp <= r11_temp;
            r_pres <= r11_ok ? r11_p + asr(r11_a + r11_b + p7, 4) : '0;
            r_pok  <= r11_ok;
        end
    end

    ptc_div #(.TW(TW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (adv),
        .i_vld      (r_v[9]),
        .i_dividend (r9_dvd),
        .i_divisor  (r9_dvs),
        .i_tag      ({r9_temp, r9_ok, r9_dbl}),
        .o_vld      (dvld),
        .o_quot     (dq),
        .o_tag      (dtag)
    );

    assign o_out_valid      = r_out_vld;
    assign o_temperature    = r_temp;
    assign o_pressure       = r_pres;
    assign o_pressure_valid = r_pok;

endmodule

@@ rtl/pressure_temp_compensation_top.sv @@
// barometric compensation, 32-bit integer scheme
// input channel: i_in_valid / o_in_ready with raw 20-bit temperature and
// pressure; one beat is one reading pair
// output channel: o_out_valid / i_out_ready with temperature (0.01 degC),
// pressure (Pa) and pressure_valid; pressure reads 0 when the divisor is 0
// config channel: i_cfg_valid / o_cfg_ready, index 0..2 selects one of the
// three 64-bit coefficient words, other indexes are dropped; write only idle
// each input beat passes through the 32-stage pipelined divider plus the
// multiply stages around it
// throughput: one beat per cycle while the receiver takes results
// when the receiver stalls, the result register holds and the whole
// pipeline freezes; a two-beat queue keeps taking input until it is full
// reset clears the coefficients to zero and empties queue and pipeline
module pressure_temp_compensation_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [19:0] i_raw_temperature,
    input  logic [19:0] i_raw_pressure,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic signed [31:0] o_temperature,
    output logic signed [31:0] o_pressure,
    output logic        o_pressure_valid,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import ptc_pkg::*;

    t_coeffs r_coeffs;
    t_item   in_item, q_item;
    logic    q_valid, q_take;
    logic [31:0] temp_w, pres_w;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeffs <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TEMP:     r_coeffs.temp_coeffs <= i_cfg_data;
                CFG_PRESS_LO: r_coeffs.press_lo    <= i_cfg_data;
                CFG_PRESS_HI: r_coeffs.press_hi    <= i_cfg_data;
                default:      r_coeffs             <= r_coeffs;
            endcase
        end
    end

    assign in_item.raw_temperature = i_raw_temperature;
    assign in_item.raw_pressure    = i_raw_pressure;

    ptc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (in_item),
        .o_valid (q_valid),
        .i_take  (q_take),
        .o_item  (q_item)
    );

    ptc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_coeffs         (r_coeffs),
        .i_valid          (q_valid),
        .i_item           (q_item),
        .o_take           (q_take),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_temperature    (temp_w),
        .o_pressure       (pres_w),
        .o_pressure_valid (o_pressure_valid)
    );

    assign o_temperature = $signed(temp_w);
    assign o_pressure    = $signed(pres_w);

endmodule

@@ rtl/ptc_chk.sv @@
module ptc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_temperature,
    input logic [31:0] o_pressure,
    input logic        o_pressure_valid
);

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat shown straight after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_temperature)
            && $stable(o_pressure) && $stable(o_pressure_valid))
        else $error("stalled result beat changed");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_pressure_valid |-> o_pressure == 32'd0)
        else $error("pressure not zero on zero divisor");

    a_no_out_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result beat without input");

endmodule

bind pressure_temp_compensation_top ptc_chk u_ptc_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_temperature    (o_temperature),
    .o_pressure       (o_pressure),
    .o_pressure_valid (o_pressure_valid)
);
